>>> src/csl_pkg.sv
// csl_pkg: shared types, token kinds and character classification for the lexer
package csl_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned KindW  = 5;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW   = $clog2(FifoDepth);
  localparam int unsigned CntW   = $clog2(FifoDepth + 1);
  localparam int unsigned MaxRes = 3;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_INT   = 2'd1,
    MODE_IDENT = 2'd2
  } scan_mode_t;

  localparam logic [2:0] KW_ZERO = 3'd0;
  localparam logic [2:0] KW_FULL = 3'd3;
  localparam logic [2:0] KW_DEAD = 3'd4;

  localparam logic [KindW-1:0] KIND_INT     = 5'd0;
  localparam logic [KindW-1:0] KIND_IDENT   = 5'd1;
  localparam logic [KindW-1:0] KIND_KEYWORD = 5'd2;
  localparam logic [KindW-1:0] KIND_PLUS    = 5'd3;
  localparam logic [KindW-1:0] KIND_MINUS   = 5'd4;
  localparam logic [KindW-1:0] KIND_STAR    = 5'd5;
  localparam logic [KindW-1:0] KIND_SLASH   = 5'd6;
  localparam logic [KindW-1:0] KIND_GT      = 5'd7;
  localparam logic [KindW-1:0] KIND_LT      = 5'd8;
  localparam logic [KindW-1:0] KIND_LPAREN  = 5'd9;
  localparam logic [KindW-1:0] KIND_RPAREN  = 5'd10;
  localparam logic [KindW-1:0] KIND_LBRACK  = 5'd11;
  localparam logic [KindW-1:0] KIND_RBRACK  = 5'd12;
  localparam logic [KindW-1:0] KIND_LBRACE  = 5'd13;
  localparam logic [KindW-1:0] KIND_RBRACE  = 5'd14;
  localparam logic [KindW-1:0] KIND_SEMI    = 5'd15;
  localparam logic [KindW-1:0] KIND_ASSIGN  = 5'd16;

  typedef struct packed {
    logic             is_close;
    logic [KindW-1:0] kind;
    logic [CharW-1:0] ch;
    logic             last;
  } res_t;

  // operator kind, zero when not an operator
  function automatic logic [KindW-1:0] op_kind(input logic [CharW-1:0] c);
    logic [KindW-1:0] k;
    begin
      case (c)
        8'h2B: k = KIND_PLUS;
        8'h2D: k = KIND_MINUS;
        8'h2A: k = KIND_STAR;
        8'h2F: k = KIND_SLASH;
        8'h3E: k = KIND_GT;
        8'h3C: k = KIND_LT;
        8'h28: k = KIND_LPAREN;
        8'h29: k = KIND_RPAREN;
        8'h5B: k = KIND_LBRACK;
        8'h5D: k = KIND_RBRACK;
        8'h7B: k = KIND_LBRACE;
        8'h7D: k = KIND_RBRACE;
        8'h3B: k = KIND_SEMI;
        8'h3D: k = KIND_ASSIGN;
        default: k = KIND_INT;
      endcase
      return k;
    end
  endfunction

  function automatic logic is_blank(input logic [CharW-1:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_digit(input logic [CharW-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // next expected character of the keyword int
  function automatic logic [CharW-1:0] kw_char(input logic [2:0] p);
    logic [CharW-1:0] c;
    begin
      case (p)
        3'd0:    c = 8'h69;
        3'd1:    c = 8'h6E;
        3'd2:    c = 8'h74;
        default: c = 8'h00;
      endcase
      return c;
    end
  endfunction

endpackage

>>> src/char_stream_lexer.sv
// char_stream_lexer: one-pass character tokenizer with a small result queue
// throughput: one input item per cycle while the queue has room; up to three result items per input item,
//   drained one per cycle while out_tready is high through a 4-entry result queue, which sets the sustained rate
// reset: rst_n synchronous active low, clears scan mode, keyword match and the queue
// an input item moves from the input register into the queue once 3 entries are free, counting one popped that cycle
module char_stream_lexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] char_code_res
  output logic [5:0]  out_tuser,  // [0] is_close, [5:1] kind
  output logic        out_tlast   // last
);

  // input register
  logic                         stg_valid_r;
  logic [csl_pkg::CharW-1:0]    stg_char_r;
  logic                         stg_eoi_r;

  // scan state
  csl_pkg::scan_mode_t          mode_r, mode_nxt;
  logic [2:0]                   kw_r, kw_nxt;

  // result queue
  csl_pkg::res_t                mem_r [csl_pkg::FifoDepth];
  logic [csl_pkg::PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [csl_pkg::CntW-1:0]     count_r;

  csl_pkg::res_t                res [csl_pkg::MaxRes];
  logic [1:0]                   n_res;
  logic                         pop, room, advance;

  csl_pkg::scan_mode_t          mode_eff;
  logic                         pending, blank, digit, cont;
  logic [csl_pkg::KindW-1:0]    op, close_kind;
  csl_pkg::res_t                close_res, char_res;

  assign pop       = out_tvalid && out_tready;
  assign room      = (count_r <= csl_pkg::CntW'(1)) ||
                     ((count_r == csl_pkg::CntW'(2)) && pop);
  assign advance   = stg_valid_r && room;
  assign in_tready = !stg_valid_r || advance;

  // classification and next state
  always_comb begin
    mode_eff = ((mode_r == csl_pkg::MODE_INT) || (mode_r == csl_pkg::MODE_IDENT)) ?
               mode_r : csl_pkg::MODE_IDLE;
    pending  = (mode_eff != csl_pkg::MODE_IDLE);
    blank    = csl_pkg::is_blank(stg_char_r);
    digit    = csl_pkg::is_digit(stg_char_r);
    op       = csl_pkg::op_kind(stg_char_r);
    cont     = ((mode_eff == csl_pkg::MODE_INT) && digit) ||
               ((mode_eff == csl_pkg::MODE_IDENT) && (op == csl_pkg::KIND_INT) && !blank);

    if (mode_eff == csl_pkg::MODE_INT) begin
      close_kind = csl_pkg::KIND_INT;
    end else if (kw_r == csl_pkg::KW_FULL) begin
      close_kind = csl_pkg::KIND_KEYWORD;
    end else begin
      close_kind = csl_pkg::KIND_IDENT;
    end

    close_res.is_close = 1'b1;
    close_res.kind     = close_kind;
    close_res.ch       = '0;
    close_res.last     = 1'b0;
    char_res.is_close  = 1'b0;
    char_res.kind      = csl_pkg::KIND_INT;
    char_res.ch        = stg_char_r;
    char_res.last      = 1'b0;

    for (int i = 0; i < csl_pkg::MaxRes; i++) begin
      res[i] = close_res;
    end
    n_res    = 2'd0;
    mode_nxt = csl_pkg::MODE_IDLE;
    kw_nxt   = csl_pkg::KW_ZERO;

    if (stg_eoi_r) begin
      if (pending) begin
        res[0] = close_res;
        n_res  = 2'd1;
      end
    end else if (cont) begin
      mode_nxt = mode_eff;
      if (mode_eff == csl_pkg::MODE_IDENT) begin
        char_res.kind = csl_pkg::KIND_IDENT;
        if ((kw_r < csl_pkg::KW_FULL) && (csl_pkg::kw_char(kw_r) == stg_char_r)) begin
          kw_nxt = kw_r + 3'd1;
        end else begin
          kw_nxt = csl_pkg::KW_DEAD;
        end
      end else begin
        kw_nxt = kw_r;
      end
      res[0] = char_res;
      n_res  = 2'd1;
    end else begin
      if (pending) begin
        res[0] = close_res;
        n_res  = 2'd1;
      end
      if (blank) begin
        mode_nxt = csl_pkg::MODE_IDLE;
      end else if (op != csl_pkg::KIND_INT) begin
        char_res.kind     = op;
        close_res.kind    = op;
        res[n_res]        = char_res;
        res[n_res + 2'd1] = close_res;
        n_res             = n_res + 2'd2;
      end else if (digit) begin
        mode_nxt   = csl_pkg::MODE_INT;
        res[n_res] = char_res;
        n_res      = n_res + 2'd1;
      end else begin
        mode_nxt      = csl_pkg::MODE_IDENT;
        kw_nxt        = (stg_char_r == csl_pkg::kw_char(csl_pkg::KW_ZERO)) ?
                        3'd1 : csl_pkg::KW_DEAD;
        char_res.kind = csl_pkg::KIND_IDENT;
        res[n_res]    = char_res;
        n_res         = n_res + 2'd1;
      end
    end

    if (n_res != 2'd0) begin
      res[n_res - 2'd1].last = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      mode_r      <= csl_pkg::MODE_IDLE;
      kw_r        <= csl_pkg::KW_ZERO;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
    end else begin
      if (in_tready) begin
        stg_valid_r <= in_tvalid;
      end
      if (advance) begin
        mode_r   <= mode_nxt;
        kw_r     <= kw_nxt;
        wr_ptr_r <= wr_ptr_r + csl_pkg::PtrW'(n_res);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + csl_pkg::PtrW'(1);
      end
      count_r <= count_r + (advance ? csl_pkg::CntW'(n_res) : csl_pkg::CntW'(0))
                 - (pop ? csl_pkg::CntW'(1) : csl_pkg::CntW'(0));
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stg_char_r <= in_tdata;
      stg_eoi_r  <= in_tlast;
    end
    if (advance) begin
      for (int i = 0; i < csl_pkg::MaxRes; i++) begin
        if (2'(i) < n_res) begin
          mem_r[wr_ptr_r + csl_pkg::PtrW'(i)] <= res[i];
        end
      end
    end
  end

  assign out_tvalid = (count_r != '0);
  assign out_tdata  = mem_r[rd_ptr_r].ch;
  assign out_tuser  = {mem_r[rd_ptr_r].kind, mem_r[rd_ptr_r].is_close};
  assign out_tlast  = mem_r[rd_ptr_r].last;

endmodule

>>> sim/lexer_token_checker.sv
`timescale 1ns / 100ps
// lexer_token_checker: predicts the token results of char_stream_lexer and checks its result stream
module lexer_token_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic [5:0] out_tuser,
  input  logic       out_tlast,
  output int         mismatches,
  output int         pending_results
);

  csl_pkg::scan_mode_t       lex_mode;
  logic [2:0]                kw_matched;
  csl_pkg::res_t             expected_tokens[$];
  csl_pkg::res_t             token_batch[$];
  logic [csl_pkg::CharW-1:0] kw_spelling[3] = '{"i", "n", "t"};

  // zero when not an operator
  function automatic logic [csl_pkg::KindW-1:0] operator_kind(
    input logic [csl_pkg::CharW-1:0] c
  );
    case (c)
      "+":     return csl_pkg::KIND_PLUS;
      "-":     return csl_pkg::KIND_MINUS;
      "*":     return csl_pkg::KIND_STAR;
      "/":     return csl_pkg::KIND_SLASH;
      ">":     return csl_pkg::KIND_GT;
      "<":     return csl_pkg::KIND_LT;
      "(":     return csl_pkg::KIND_LPAREN;
      ")":     return csl_pkg::KIND_RPAREN;
      "[":     return csl_pkg::KIND_LBRACK;
      "]":     return csl_pkg::KIND_RBRACK;
      "{":     return csl_pkg::KIND_LBRACE;
      "}":     return csl_pkg::KIND_RBRACE;
      ";":     return csl_pkg::KIND_SEMI;
      "=":     return csl_pkg::KIND_ASSIGN;
      default: return csl_pkg::KIND_INT;
    endcase
  endfunction

  function automatic logic blank_char(input logic [csl_pkg::CharW-1:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic digit_char(input logic [csl_pkg::CharW-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic void emit_token(input logic close,
                                     input logic [csl_pkg::KindW-1:0] k,
                                     input logic [csl_pkg::CharW-1:0] c);
    csl_pkg::res_t r;
    r.is_close  = close;
    r.kind      = k;
    r.ch        = c;
    r.last      = 1'b0;
    token_batch = {token_batch, r};
  endfunction

  function automatic void close_token();
    if (lex_mode == csl_pkg::MODE_INT) begin
      emit_token(1'b1, csl_pkg::KIND_INT, 8'h00);
    end else if (lex_mode == csl_pkg::MODE_IDENT) begin
      emit_token(1'b1, (kw_matched == csl_pkg::KW_FULL) ?
                       csl_pkg::KIND_KEYWORD : csl_pkg::KIND_IDENT, 8'h00);
    end
    lex_mode   = csl_pkg::MODE_IDLE;
    kw_matched = csl_pkg::KW_ZERO;
  endfunction

  function automatic void lex_char(input logic [csl_pkg::CharW-1:0] c, input logic eoi);
    logic [csl_pkg::KindW-1:0] op;
    logic                      continued;
    op        = operator_kind(c);
    continued = 1'b0;
    token_batch.delete();
    if (eoi) begin
      close_token();
    end else begin
      if (lex_mode == csl_pkg::MODE_INT) begin
        if (digit_char(c)) begin
          emit_token(1'b0, csl_pkg::KIND_INT, c);
          continued = 1'b1;
        end else begin
          close_token();
        end
      end else if (lex_mode == csl_pkg::MODE_IDENT) begin
        // digits and any non-operator, non-blank byte continue an identifier
        if (op == csl_pkg::KIND_INT && !blank_char(c)) begin
          emit_token(1'b0, csl_pkg::KIND_IDENT, c);
          if (kw_matched < csl_pkg::KW_FULL && kw_spelling[kw_matched] == c) begin
            kw_matched = kw_matched + 3'd1;
          end else begin
            kw_matched = csl_pkg::KW_DEAD;
          end
          continued = 1'b1;
        end else begin
          close_token();
        end
      end
      if (!continued && !blank_char(c)) begin
        if (op != csl_pkg::KIND_INT) begin
          emit_token(1'b0, op, c);
          emit_token(1'b1, op, 8'h00);
        end else if (digit_char(c)) begin
          lex_mode = csl_pkg::MODE_INT;
          emit_token(1'b0, csl_pkg::KIND_INT, c);
        end else begin
          lex_mode   = csl_pkg::MODE_IDENT;
          kw_matched = (c == kw_spelling[0]) ? csl_pkg::KW_ZERO + 3'd1 : csl_pkg::KW_DEAD;
          emit_token(1'b0, csl_pkg::KIND_IDENT, c);
        end
      end
    end
    if (token_batch.size() > 0) begin
      token_batch[token_batch.size() - 1].last = 1'b1;
    end
    foreach (token_batch[i]) begin
      expected_tokens = {expected_tokens, token_batch[i]};
    end
  endfunction

  always @(posedge clk) begin
    csl_pkg::res_t got;
    csl_pkg::res_t want;
    if (!rst_n) begin
      lex_mode   = csl_pkg::MODE_IDLE;
      kw_matched = csl_pkg::KW_ZERO;
      expected_tokens.delete();
      mismatches = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        lex_char(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        got.is_close = out_tuser[0];
        got.kind     = out_tuser[5:1];
        got.ch       = out_tdata;
        got.last     = out_tlast;
        if (expected_tokens.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none", $time);
          $display("%0t:   actual close=%0b kind=%0d char=%02h last=%0b",
                   $time, got.is_close, got.kind, got.ch, got.last);
        end else begin
          want = expected_tokens.pop_front();
          if (got.is_close !== want.is_close || got.kind !== want.kind ||
              got.ch !== want.ch || got.last !== want.last) begin
            mismatches++;
            $display("%0t: result mismatch, expected close=%0b kind=%0d char=%02h last=%0b",
                     $time, want.is_close, want.kind, want.ch, want.last);
            $display("%0t:                  actual   close=%0b kind=%0d char=%02h last=%0b",
                     $time, got.is_close, got.kind, got.ch, got.last);
          end
        end
      end
    end
    pending_results = expected_tokens.size();
  end

endmodule

>>> sim/tb_char_stream_lexer.sv
`timescale 1ns / 100ps
// tb_char_stream_lexer: character stimulus, receiver stalls and verdict for char_stream_lexer
module tb_char_stream_lexer;

  localparam int QuietLimit  = 2000;
  localparam int DrainCycles = 40;
  localparam int StallCycles = 64;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tready = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;
  logic [5:0] out_tuser;
  logic       out_tlast;

  int mismatches;
  int pending_results;
  int send_idle_pct  = 28;
  int recv_idle_pct  = 80;
  int items_sent     = 0;
  int quiet_cycles   = 0;
  bit long_stall_req = 1'b0;

  logic [7:0] op_chars[14]   = '{"+", "-", "*", "/", ">", "<", "(", ")",
                                 "[", "]", "{", "}", ";", "="};
  logic [7:0] blank_chars[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  logic [7:0] punct_chars[8] = '{"!", "#", "$", "%", ".", ",", ":", "@"};
  logic [7:0] kw_text[3]     = '{"i", "n", "t"};

  char_stream_lexer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  lexer_token_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .mismatches      (mismatches),
    .pending_results (pending_results)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // receiver, with one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_tready <= 1'b0;
        repeat (StallCycles) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_tvalid && in_tready) || (out_tvalid && out_tready))) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("char_stream_lexer verification failed");
        $finish;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= eoi;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], 1'b0);
    end
  endtask

  function automatic logic [7:0] ident_char(input bit allow_digit);
    int r;
    case ($urandom_range(allow_digit ? 10 : 8))
      0, 1, 2: return 8'($urandom_range("z", "a"));
      3:       return 8'($urandom_range("Z", "A"));
      4:       return "_";
      5:       return 8'($urandom_range(8'hFF, 8'h80));
      6: begin
        // control bytes that are not blanks
        r = $urandom_range(26, 0);
        return 8'((r < 9) ? r : r + 5);
      end
      7:       return punct_chars[$urandom_range(7)];
      8:       return kw_text[$urandom_range(2)];
      default: return 8'($urandom_range("9", "0"));
    endcase
  endfunction

  task automatic send_token();
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 12) begin
      send_text("int");
    end else if (pick < 22) begin
      // partial or overlong keyword spellings
      len = $urandom_range(3, 1);
      for (int i = 0; i < len; i++) send_char(kw_text[i], 1'b0);
      send_char(ident_char(1'b1), 1'b0);
    end else if (pick < 45) begin
      len = $urandom_range(6, 1);
      send_char(ident_char(1'b0), 1'b0);
      repeat (len - 1) send_char(ident_char(1'b1), 1'b0);
    end else if (pick < 65) begin
      len = $urandom_range(5, 1);
      repeat (len) send_char(8'($urandom_range("9", "0")), 1'b0);
    end else if (pick < 85) begin
      send_char(op_chars[$urandom_range(13)], 1'b0);
    end else if (pick < 91) begin
      send_char(blank_chars[$urandom_range(5)], 1'b0);
    end else if (pick < 96) begin
      send_char(8'($urandom), 1'b1);
    end else begin
      send_char(8'($urandom), 1'b0);
    end
    if (pick < 65 && $urandom_range(1)) begin
      send_char(blank_chars[$urandom_range(5)], 1'b0);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // keyword, integer into identifier, every operator, blanks and end of input
    send_text("int;12x7+-*/><()[]{}=9 ");
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'hA5, 1'b1);
    send_char(8'h00, 1'b1);
    send_char(8'h0D, 1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct  = 0;
          recv_idle_pct  = 0;
          long_stall_req = 1'b1;
        end
      endcase
      while (items_sent < 28 + 74 * (ph + 1)) send_token();
    end
    send_char(8'h20, 1'b1);
    in_tvalid <= 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && pending_results == 0) begin
      $display("char_stream_lexer verification clean");
    end else begin
      $display("char_stream_lexer verification failed");
    end
    $finish;
  end

endmodule

>>> char_stream_lexer.f
src/csl_pkg.sv
src/char_stream_lexer.sv
sim/lexer_token_checker.sv
sim/tb_char_stream_lexer.sv
